FILE: rtl/ufn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufn_pkg
// Widths, pipeline depths and a shared helper for the unit face normal block.
// ----------------------------------------------------------------------------
package ufn_pkg;

    localparam int CW         = 16;             // vertex coordinate, Q8.8
    localparam int DFW        = CW + 1;         // coordinate difference
    localparam int PW         = 2 * CW + 1;     // one cross-product term
    localparam int AW         = PW + 2;         // normal component a, b or c
    localparam int MW         = 33;             // component magnitude
    localparam int LOW_W      = 17;             // low half of a magnitude
    localparam int HIGH_W     = MW - LOW_W;     // high half of a magnitude
    localparam int SQW        = 2 * MW;         // magnitude squared
    localparam int SW         = SQW + 2;        // sum of three squares
    localparam int LSH        = 30;             // (2^15 * mag)^2 = mag^2 << 30
    localparam int DW         = SQW + LSH;      // remainder of the root search
    localparam int RW         = 16;             // root bits, one per stage
    localparam int ROOT_STEPS = RW;
    localparam int PPW        = SW + RW;        // running sum * root
    localparam int TW         = PPW + RW + 1;   // trial term of one step
    localparam int OW         = 16;             // Q1.14 output
    localparam int FRONT_STAGES = 5;
    localparam int LATENCY    = FRONT_STAGES + ROOT_STEPS + 1;

    // u * (w1 - w2), exact in PW bits
    function automatic logic signed [PW-1:0] mul_diff(
        input logic signed [CW-1:0] u,
        input logic signed [CW-1:0] w1,
        input logic signed [CW-1:0] w2
    );
        logic signed [DFW-1:0] diff;
        diff = DFW'(w1) - DFW'(w2);
        return PW'(u) * PW'(diff);
    endfunction

endpackage

FILE: rtl/ufn_root_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufn_root_pipe
// Pipelined digit-by-digit search for floor(sqrt(lhs / sum)), one root bit
// per stage, followed by halving to the rounded Q1.14 magnitude and sign.
// ----------------------------------------------------------------------------
module ufn_root_pipe (
    input  logic                           clk,
    input  logic [ufn_pkg::SW-1:0]         sum,
    input  logic [ufn_pkg::DW-1:0]         lhs,
    input  logic                           neg,
    output logic signed [ufn_pkg::OW-1:0]  normal
);
    import ufn_pkg::*;

    logic [DW-1:0]  d_reg [0:ROOT_STEPS-1];
    logic [PPW-1:0] p_reg [0:ROOT_STEPS-1];
    logic [SW-1:0]  s_reg [0:ROOT_STEPS-1];
    logic [RW-1:0]  m_reg [0:ROOT_STEPS-1];
    logic           n_reg [0:ROOT_STEPS-1];

    genvar i;
    generate
        for (i = 0; i < ROOT_STEPS; i++)
        begin : g_step
            localparam int J = ROOT_STEPS - 1 - i;
            logic [DW-1:0]  d_in, d_next;
            logic [PPW-1:0] p_in, p_next;
            logic [SW-1:0]  s_in;
            logic [RW-1:0]  m_in, m_next;
            logic           n_in;
            logic [TW-1:0]  term;
            logic           take;

            if (i == 0)
            begin : g_first
                assign d_in = lhs;
                assign p_in = '0;
                assign s_in = sum;
                assign m_in = '0;
                assign n_in = neg;
            end
            else
            begin : g_rest
                assign d_in = d_reg[i-1];
                assign p_in = p_reg[i-1];
                assign s_in = s_reg[i-1];
                assign m_in = m_reg[i-1];
                assign n_in = n_reg[i-1];
            end

            // try setting root bit J: (m + 2^J)^2 * s - m^2 * s
            always_comb
            begin
                term   = (TW'(p_in) << (J + 1)) + (TW'(s_in) << (2 * J));
                take   = term <= TW'(d_in);
                d_next = take ? DW'(TW'(d_in) - term) : d_in;
                p_next = take ? p_in + (PPW'(s_in) << J) : p_in;
                m_next = take ? (m_in | (RW'(1) << J)) : m_in;
            end

            always_ff @(posedge clk)
            begin
                d_reg[i] <= d_next;
                p_reg[i] <= p_next;
                s_reg[i] <= s_in;
                m_reg[i] <= m_next;
                n_reg[i] <= n_in;
            end
        end
    endgenerate

    // count odd roots up to the floor: (m + 1) / 2
    logic [RW:0]   m_inc;
    logic [OW-1:0] k;

    always_comb
    begin
        m_inc  = (RW + 1)'(m_reg[ROOT_STEPS-1]) + (RW + 1)'(1);
        k      = OW'(m_inc >> 1);
        normal = n_reg[ROOT_STEPS-1] ? -$signed(k) : $signed(k);
    end

endmodule

FILE: rtl/unit_face_normal_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unit_face_normal_top
// Unit normal of a face from three Q8.8 vertices, as Q1.14 rounded to nearest.
// ----------------------------------------------------------------------------
// One face beat may be issued on every clock cycle: busy never rises, and a
// beat is taken whenever start is high. Every face yields exactly one result
// beat, shown for one cycle with done high. The result passes through the 5
// front stages (cross product, sums, split squares, square assembly, sum of
// squares) and the 16 root stages, one root bit each, plus the output
// register. The receiver cannot stall, so it must take each result beat in
// the cycle it is shown. A face whose normal has zero length gives
// degenerate high and zero components.
// ----------------------------------------------------------------------------
module unit_face_normal_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [ufn_pkg::CW-1:0] first_x,
    input  logic signed [ufn_pkg::CW-1:0] first_y,
    input  logic signed [ufn_pkg::CW-1:0] first_z,
    input  logic signed [ufn_pkg::CW-1:0] second_x,
    input  logic signed [ufn_pkg::CW-1:0] second_y,
    input  logic signed [ufn_pkg::CW-1:0] second_z,
    input  logic signed [ufn_pkg::CW-1:0] third_x,
    input  logic signed [ufn_pkg::CW-1:0] third_y,
    input  logic signed [ufn_pkg::CW-1:0] third_z,
    output logic                          done,
    output logic signed [ufn_pkg::OW-1:0] normal_x,
    output logic signed [ufn_pkg::OW-1:0] normal_y,
    output logic signed [ufn_pkg::OW-1:0] normal_z,
    output logic                          degenerate
);
    import ufn_pkg::*;

    // Nothing downstream can stall.
    assign busy = 1'b0;

    logic take_beat;
    assign take_beat = start & ~busy;

    // ---------------- stage 1: nine cross-product terms ----------------
    logic                 v1_reg;
    logic signed [PW-1:0] prod_reg [0:8];
    logic signed [PW-1:0] prod_next [0:8];

    always_comb
    begin
        // a from y and z
        prod_next[0] = mul_diff(first_y,  second_z, third_z);
        prod_next[1] = mul_diff(second_y, third_z,  first_z);
        prod_next[2] = mul_diff(third_y,  first_z,  second_z);
        // b from z and x
        prod_next[3] = mul_diff(first_z,  second_x, third_x);
        prod_next[4] = mul_diff(second_z, third_x,  first_x);
        prod_next[5] = mul_diff(third_z,  first_x,  second_x);
        // c from x and y
        prod_next[6] = mul_diff(first_x,  second_y, third_y);
        prod_next[7] = mul_diff(second_x, third_y,  first_y);
        prod_next[8] = mul_diff(third_x,  first_y,  second_y);
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 9; n++)
        begin
            prod_reg[n] <= prod_next[n];
        end
    end

    // ---------------- stage 2: components a, b, c ----------------
    logic                 v2_reg;
    logic signed [AW-1:0] comp_reg [0:2];

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 3; n++)
        begin
            comp_reg[n] <= AW'(prod_reg[3*n]) + AW'(prod_reg[3*n+1])
                         + AW'(prod_reg[3*n+2]);
        end
    end

    // ---------------- stage 3: magnitude split into partial squares ------
    logic              v3_reg;
    logic              neg3_reg [0:2];
    logic [2*HIGH_W-1:0]       hh_reg [0:2];
    logic [HIGH_W+LOW_W-1:0]   hl_reg [0:2];
    logic [2*LOW_W-1:0]        ll_reg [0:2];
    logic [MW-1:0]     mag_next [0:2];

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            mag_next[n] = MW'(comp_reg[n][AW-1] ? -comp_reg[n] : comp_reg[n]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 3; n++)
        begin
            neg3_reg[n] <= comp_reg[n][AW-1];
            hh_reg[n]   <= (2*HIGH_W)'(mag_next[n][MW-1:LOW_W])
                         * (2*HIGH_W)'(mag_next[n][MW-1:LOW_W]);
            hl_reg[n]   <= (HIGH_W+LOW_W)'(mag_next[n][MW-1:LOW_W])
                         * (HIGH_W+LOW_W)'(mag_next[n][LOW_W-1:0]);
            ll_reg[n]   <= (2*LOW_W)'(mag_next[n][LOW_W-1:0])
                         * (2*LOW_W)'(mag_next[n][LOW_W-1:0]);
        end
    end

    // ---------------- stage 4: assemble the squares ----------------
    logic           v4_reg;
    logic           neg4_reg [0:2];
    logic [SQW-1:0] sq_reg [0:2];

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 3; n++)
        begin
            neg4_reg[n] <= neg3_reg[n];
            sq_reg[n]   <= (SQW'(hh_reg[n]) << (2 * LOW_W))
                         + (SQW'(hl_reg[n]) << (LOW_W + 1))
                         + SQW'(ll_reg[n]);
        end
    end

    // ---------------- stage 5: sum of squares, scaled left sides --------
    logic          v5_reg;
    logic          neg5_reg [0:2];
    logic [SW-1:0] sum_reg;
    logic [DW-1:0] lhs_reg [0:2];
    logic          degen5_reg;
    logic [SW-1:0] sum_next;

    assign sum_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        degen5_reg <= (sum_next == '0);
        for (int n = 0; n < 3; n++)
        begin
            neg5_reg[n] <= neg4_reg[n];
            lhs_reg[n]  <= DW'(sq_reg[n]) << LSH;
        end
    end

    // ---------------- root stages, one lane per component ----------------
    logic signed [OW-1:0] root_out [0:2];

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            ufn_root_pipe u_root (
                .clk    (clk),
                .sum    (sum_reg),
                .lhs    (lhs_reg[g]),
                .neg    (neg5_reg[g]),
                .normal (root_out[g])
            );
        end
    endgenerate

    // hold valid and the degenerate mark alongside the root stages
    logic [ROOT_STEPS-1:0] vline_reg,  vline_next;
    logic [ROOT_STEPS-1:0] dline_reg,  dline_next;

    assign vline_next = {vline_reg[ROOT_STEPS-2:0], v5_reg};
    assign dline_next = {dline_reg[ROOT_STEPS-2:0], degen5_reg};

    always_ff @(posedge clk)
    begin
        dline_reg <= dline_next;
    end

    // ---------------- valid bits ----------------
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            vline_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v1_reg    <= take_beat;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            vline_reg <= vline_next;
            done_reg  <= vline_reg[ROOT_STEPS-1];
        end
    end

    // ---------------- output register ----------------
    logic signed [OW-1:0] nx_reg, ny_reg, nz_reg;
    logic                 degen_reg;
    logic                 degen_last;

    assign degen_last = dline_reg[ROOT_STEPS-1];

    // drop the root results of a zero-length normal
    always_ff @(posedge clk)
    begin
        degen_reg <= degen_last;
        nx_reg    <= degen_last ? '0 : root_out[0];
        ny_reg    <= degen_last ? '0 : root_out[1];
        nz_reg    <= degen_last ? '0 : root_out[2];
    end

    assign done       = done_reg;
    assign normal_x   = nx_reg;
    assign normal_y   = ny_reg;
    assign normal_z   = nz_reg;
    assign degenerate = degen_reg;

endmodule

FILE: rtl/ufn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufn_checker
// Port-level checks for the unit face normal block, bound to the top level.
// ----------------------------------------------------------------------------
module ufn_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic signed [ufn_pkg::OW-1:0] normal_x,
    input logic signed [ufn_pkg::OW-1:0] normal_y,
    input logic signed [ufn_pkg::OW-1:0] normal_z,
    input logic                          degenerate
);
    import ufn_pkg::*;

    // every accepted beat returns exactly once after the fixed latency
    a_latency_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result beat missing at fixed latency");

    a_latency_none: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !done)
        else $error("result beat without a matching start");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |->
            (normal_x == '0 && normal_y == '0 && normal_z == '0))
        else $error("degenerate result with nonzero components");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (normal_x >= -16'sd16384 && normal_x <= 16'sd16384 &&
                  normal_y >= -16'sd16384 && normal_y <= 16'sd16384 &&
                  normal_z >= -16'sd16384 && normal_z <= 16'sd16384))
        else $error("normal component outside unit range");

endmodule

bind unit_face_normal_top ufn_checker u_ufn_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .degenerate (degenerate)
);
